[rtl/sfct_pkg.sv]
// ----------------------------------------------------------------------------
// sfct_pkg
// Shared constants, field layouts and control types of the sphere frustum
// culling test unit.
// ----------------------------------------------------------------------------
package sfct_pkg;

    // plane store geometry and fixed-point format
    localparam int NUM_PLANES      = 6;
    localparam int FRAC_BITS       = 16;
    localparam int COEFS_PER_PLANE = 4;

    // field widths
    localparam int COEF_W      = 32;
    localparam int RAD_W       = 31;
    localparam int PLANE_IDX_W = 3;
    localparam int COEF_IDX_W  = 2;
    localparam int PASS_W      = 3;
    localparam int MASK_W      = 6;

    // derived widths
    localparam int PLANE_AW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int IN_FIELD_W = PLANE_IDX_W + COEF_IDX_W + 4 * COEF_W + RAD_W;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int IN_PAD_W   = IN_DATA_W - IN_FIELD_W;
    localparam int RES_W      = 1 + PASS_W + MASK_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [PASS_W-1:0] PASS_MAX = '1;

    // command codes (tuser)
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    // coefficient codes
    localparam logic [COEF_IDX_W-1:0] COEF_A = 2'd0;
    localparam logic [COEF_IDX_W-1:0] COEF_B = 2'd1;
    localparam logic [COEF_IDX_W-1:0] COEF_C = 2'd2;
    localparam logic [COEF_IDX_W-1:0] COEF_D = 2'd3;

    // input tdata layout, last declared field in the lowest bits
    typedef struct packed {
        logic [IN_PAD_W-1:0]    pad;
        logic [RAD_W-1:0]       radius;
        logic signed [COEF_W-1:0] pos_z;
        logic signed [COEF_W-1:0] pos_y;
        logic signed [COEF_W-1:0] pos_x;
        logic signed [COEF_W-1:0] coef_value;
        logic [COEF_IDX_W-1:0]  coef_index;
        logic [PLANE_IDX_W-1:0] plane_index;
    } in_item_t;

    // result layout, last declared field in the lowest bits
    typedef struct packed {
        logic [MASK_W-1:0] fail_mask;
        logic [PASS_W-1:0] planes_passed;
        logic              inside_res;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic                wr;
        logic                start;
        logic                issue;
        logic                publish;
        logic [PLANE_AW-1:0] plane;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/sfct_datapath.sv]
// ----------------------------------------------------------------------------
// sfct_datapath
// Plane store, three-lane multiply stage, two adder stages with the radius
// compare, result accumulation and the output register.
// ----------------------------------------------------------------------------
module sfct_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sfct_pkg::in_item_t  item,
    input  sfct_pkg::dp_cmd_t   cmd,
    output sfct_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output sfct_pkg::result_t   res
);
    import sfct_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [NUM_PLANES][COEFS_PER_PLANE];
    logic signed [COEF_W-1:0] coef_row [COEFS_PER_PLANE];
    logic                     coef_we;

    logic signed [COEF_W-1:0] x_reg, y_reg, z_reg;
    logic [RAD_W-1:0]         r_reg;

    // stage 1: products
    logic                     s1_valid_reg;
    logic [PLANE_AW-1:0]      s1_plane_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg, prod_c_reg;
    logic signed [ACC_W-1:0]  d_term_reg;
    logic signed [PROD_W-1:0] prod_a_next, prod_b_next, prod_c_next;
    logic signed [ACC_W-1:0]  d_term_next;

    // stage 2: partial sums
    logic                     s2_valid_reg;
    logic [PLANE_AW-1:0]      s2_plane_reg;
    logic signed [ACC_W-1:0]  sum_ab_reg, sum_cd_reg;

    // stage 3: final sum, compare, accumulate
    logic signed [ACC_W-1:0]  distance;
    logic signed [ACC_W-1:0]  r_scaled;
    logic                     fail;
    logic [PASS_W-1:0]        pass_reg;
    logic [MASK_W-1:0]        mask_reg;
    logic                     all_reg;

    logic                     out_valid_reg;
    result_t                  res_reg;

    assign coef_we = cmd.wr && (int'(item.plane_index) < NUM_PLANES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int c = 0; c < COEFS_PER_PLANE; c++)
                begin
                    coef_reg[p][c] <= '0;
                end
            end
        end
        else if (coef_we)
        begin
            coef_reg[item.plane_index[PLANE_AW-1:0]][item.coef_index] <= item.coef_value;
        end
    end

    always_comb
    begin
        for (int c = 0; c < COEFS_PER_PLANE; c++)
        begin
            coef_row[c] = coef_reg[cmd.plane][c];
        end
    end

    // sphere capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= item.pos_x;
            y_reg <= item.pos_y;
            z_reg <= item.pos_z;
            r_reg <= item.radius;
        end
    end

    always_comb
    begin
        prod_a_next = PROD_W'(coef_row[COEF_A]) * PROD_W'(x_reg);
        prod_b_next = PROD_W'(coef_row[COEF_B]) * PROD_W'(y_reg);
        prod_c_next = PROD_W'(coef_row[COEF_C]) * PROD_W'(z_reg);
        // d brought to the scale of the products
        d_term_next = ACC_W'(coef_row[COEF_D]) <<< FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_plane_reg <= cmd.plane;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        prod_c_reg   <= prod_c_next;
        d_term_reg   <= d_term_next;
        s2_plane_reg <= s1_plane_reg;
        sum_ab_reg   <= ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg);
        sum_cd_reg   <= ACC_W'(prod_c_reg) + d_term_reg;
    end

    assign distance = sum_ab_reg + sum_cd_reg;
    assign r_scaled = $signed(ACC_W'(r_reg) << FRAC_BITS);
    assign fail     = distance > r_scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= '0;
            mask_reg <= '0;
            all_reg  <= 1'b1;
        end
        else if (cmd.start)
        begin
            pass_reg <= '0;
            mask_reg <= '0;
            all_reg  <= 1'b1;
        end
        else if (s2_valid_reg)
        begin
            // planes beyond the mask width shift out of the mask
            if (fail)
            begin
                mask_reg <= mask_reg | (MASK_W'(1) << s2_plane_reg);
                all_reg  <= 1'b0;
            end
            else if (pass_reg != PASS_MAX)
            begin
                pass_reg <= pass_reg + PASS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            res_reg.inside_res    <= all_reg;
            res_reg.planes_passed <= pass_reg;
            res_reg.fail_mask     <= mask_reg;
        end
    end

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.out_free  = !out_valid_reg || m_ready;
    assign m_valid          = out_valid_reg;
    assign res              = res_reg;

endmodule

[rtl/sfct_ctrl.sv]
// ----------------------------------------------------------------------------
// sfct_ctrl
// Sequencer: takes transactions, steps the plane counter through the shared
// multiply unit, waits for the pipeline and hands the result to the output.
// ----------------------------------------------------------------------------
module sfct_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    input  logic                 command,
    output logic                 s_ready,
    output sfct_pkg::dp_cmd_t    cmd,
    input  sfct_pkg::dp_status_t status
);
    import sfct_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [PLANE_AW-1:0] LAST_PLANE = PLANE_AW'(NUM_PLANES - 1);

    logic [1:0]          state_reg, state_next;
    logic [PLANE_AW-1:0] plane_reg, plane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        plane_next  = plane_reg;
        s_ready     = 1'b0;
        cmd.wr      = 1'b0;
        cmd.start   = 1'b0;
        cmd.issue   = 1'b0;
        cmd.publish = 1'b0;
        cmd.plane   = plane_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    if (command == CMD_TEST)
                    begin
                        cmd.start  = 1'b1;
                        plane_next = '0;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (plane_reg == LAST_PLANE)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    plane_next = plane_reg + PLANE_AW'(1);
                end
            end
            ST_DRAIN:
            begin
                // result moves out once the multiply and adder stages are empty and the output slot is free
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sphere_frustum_cull_test_unit.sv]
// ----------------------------------------------------------------------------
// sphere_frustum_cull_test_unit
// Sphere against frustum planes test: load transactions fill the plane store,
// test transactions give passing count, fail mask and inside flag.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         tuser command; tdata plane and coefficient, sphere
//  m_axis    out        tdata inside flag, passed count, fail mask
//
//  a load leaves the unit idle; the next transaction is taken in the following cycle
//  a test issues one plane a cycle, with no stall, through the
//  shared three-multiplier stage, then passes two adder stages and the output hand-off
//  reset clears the plane store to zero and empties the pipeline and output
//  a result waiting on m_axis does not block new transactions; a second result
//  waits in the drain state until the first is taken
// ----------------------------------------------------------------------------
module sphere_frustum_cull_test_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // plane_index, coef_index, coef_value, pos_x, pos_y, pos_z, radius, zero pad
    input  logic [sfct_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // inside_res, planes_passed, fail_mask, zero pad
    output logic [sfct_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sfct_pkg::*;

    in_item_t   in_item;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    res;

    assign in_item = in_item_t'(s_axis_tdata);

    sfct_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .command (s_axis_tuser),
        .s_ready (s_axis_tready),
        .cmd     (cmd),
        .status  (status)
    );

    sfct_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (in_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .res     (res)
    );

    assign m_axis_tdata = OUT_DATA_W'(res);

`ifndef ASSERT_OFF
    // a result is never moved into an occupied output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending output transaction");

    // no transaction taken while planes are being issued
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !s_axis_tready)
        else $error("input accepted during plane issue");

    // inside flag agrees with the mask when every plane fits the mask
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((NUM_PLANES > MASK_W) || (res.inside_res == (res.fail_mask == '0))))
        else $error("inside flag disagrees with fail mask");

    // every plane either passes or fails
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((NUM_PLANES > MASK_W) ||
            (int'(res.planes_passed) + $countones(res.fail_mask) == NUM_PLANES)))
        else $error("passed count and fail mask do not cover all planes");
`endif

endmodule
